[hw/rtl/rect_fill_outline_raster_macros.svh]
// Assertion macros used by the rectangle rasterizer RTL.
`ifndef RECT_FILL_OUTLINE_RASTER_MACROS_SVH
`define RECT_FILL_OUTLINE_RASTER_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define RFOR_ASSERT_NOW(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies outcome in the next.
`define RFOR_ASSERT_NEXT(label, cond, nxt, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) else $error(msg);

`endif

[hw/rtl/rfor_pkg.sv]
// Types and constants of the rectangle fill and outline rasterizer.
package rfor_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_DRAW  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_IGNORED = 2'd2,
    STAT_OUTSIDE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_BG     = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_DRAW,
    S_READ
  } state_e;

  localparam logic [7:0] KIND_FILLED  = 8'h52;
  localparam logic [7:0] KIND_OUTLINE = 8'h72;

  localparam logic [8:0] WIDTH_RESET  = 9'd1;
  localparam logic [8:0] HEIGHT_RESET = 9'd1;
  localparam logic [7:0] BG_RESET     = 8'd32;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [7:0]         rect_kind;
    logic signed [23:0] rect_left;
    logic signed [23:0] rect_top;
    logic signed [23:0] rect_width;
    logic signed [23:0] rect_height;
    logic [7:0]         fill_char;
    logic [7:0]         pixel_col;
    logic [7:0]         pixel_row;
  } in_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] pixel_char;
  } out_res_t;

endpackage

[hw/rtl/rect_fill_outline_raster.sv]
// Rectangle fill and outline rasterizer over a character canvas memory.
//
//   channel | signals                               | transfer
//   in      | start, busy, in_req                   | start && !busy
//   out     | out_valid, out_res                    | out_valid, one cycle, no stall
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_wdata | cfg_valid && cfg_ready
//
// After reset a clearing pass zeroes the canvas, with busy high.
// Clear: fills the canvas with the background character, one memory write per cycle.
// Draw: one pixel per cycle within each row of the in-use area.
// Read: via the registered memory read port; refusals and NOPs answer next cycle.
// Configuration writes are taken in every cycle, including during the clearing pass.
`include "rect_fill_outline_raster_macros.svh"

module rect_fill_outline_raster #(
  parameter int MAX_SIDE  = 256,
  parameter int FRAC_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  rfor_pkg::in_req_t in_req,
  output logic              out_valid,
  output rfor_pkg::out_res_t out_res,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [8:0]        cfg_wdata
);

  localparam int IDXW  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int CNTW  = IDXW + 1;
  localparam int SW    = (CNTW > 9) ? CNTW : 9;
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW    = (CNTW + FRAC_BITS > 25) ? CNTW + FRAC_BITS : 25;
  localparam int CW    = XW + 2;
  localparam logic [AW-1:0]        LAST_ADDR = AW'(DEPTH - 1);
  localparam logic signed [CW-1:0] ONE       = CW'(1) << FRAC_BITS;

  rfor_pkg::state_e state_r, state_nxt;

  logic [8:0]    width_r, height_r;
  logic [7:0]    bg_r;
  logic          stop_r, stop_nxt;
  logic [AW-1:0] sweep_r, sweep_nxt;
  logic [CNTW-1:0] row_r, row_nxt, col_r, col_nxt;
  logic          out_valid_r, out_valid_nxt;
  rfor_pkg::out_res_t out_res_r, out_res_nxt;

  logic signed [CW-1:0] left_r, right_r, lefto_r, rightm_r;
  logic signed [CW-1:0] top_r, bot_r, topo_r, botm_r;
  logic                 filled_r;
  logic [7:0]           fc_r;

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;

  logic            in_acc;
  logic [SW-1:0]   w_full, h_full;
  logic [CNTW-1:0] w_eff, h_eff;
  logic            rect_bad, kind_ok, read_out;
  logic signed [CW-1:0] in_left, in_top, in_right, in_bot, x_pos, y_pos;
  logic            covered;

  assign busy      = (state_r != rfor_pkg::S_IDLE);
  assign in_acc    = start && !busy;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  assign w_full = (SW'(width_r) > SW'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(width_r);
  assign h_full = (SW'(height_r) > SW'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(height_r);
  assign w_eff  = CNTW'(w_full);
  assign h_eff  = CNTW'(h_full);

  assign kind_ok  = (in_req.rect_kind == rfor_pkg::KIND_FILLED) ||
                    (in_req.rect_kind == rfor_pkg::KIND_OUTLINE);
  assign rect_bad = (in_req.rect_width <= 24'sd0) || (in_req.rect_height <= 24'sd0) ||
                    !kind_ok;
  assign read_out = (SW'(in_req.pixel_col) >= w_full) || (SW'(in_req.pixel_row) >= h_full);

  assign in_left  = CW'(in_req.rect_left);
  assign in_top   = CW'(in_req.rect_top);
  assign in_right = in_left + CW'(in_req.rect_width);
  assign in_bot   = in_top + CW'(in_req.rect_height);

  assign x_pos = $signed(CW'(col_r)) <<< FRAC_BITS;
  assign y_pos = $signed(CW'(row_r)) <<< FRAC_BITS;
  assign covered = (x_pos >= left_r) && (x_pos <= right_r) &&
                   (y_pos >= top_r) && (y_pos <= bot_r) &&
                   (filled_r || (x_pos < lefto_r) || (x_pos > rightm_r) ||
                    (y_pos < topo_r) || (y_pos > botm_r));

  assign rd_addr = AW'(AW'(in_req.pixel_row) * AW'(MAX_SIDE) + AW'(in_req.pixel_col));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= rfor_pkg::WIDTH_RESET;
      height_r <= rfor_pkg::HEIGHT_RESET;
      bg_r     <= rfor_pkg::BG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rfor_pkg::CFG_WIDTH:  width_r  <= cfg_wdata;
        rfor_pkg::CFG_HEIGHT: height_r <= cfg_wdata;
        rfor_pkg::CFG_BG:     bg_r     <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rfor_pkg::S_INIT;
      stop_r      <= 1'b0;
      sweep_r     <= '0;
      row_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stop_r      <= stop_nxt;
      sweep_r     <= sweep_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    if (in_acc) begin
      left_r   <= in_left;
      right_r  <= in_right;
      lefto_r  <= in_left + ONE;
      rightm_r <= in_right - ONE;
      top_r    <= in_top;
      bot_r    <= in_bot;
      topo_r   <= in_top + ONE;
      botm_r   <= in_bot - ONE;
      filled_r <= (in_req.rect_kind == rfor_pkg::KIND_FILLED);
      fc_r     <= in_req.fill_char;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    stop_nxt      = stop_r;
    sweep_nxt     = sweep_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = '{status: rfor_pkg::STAT_DONE, pixel_char: 8'd0};
    mem_we        = 1'b0;
    mem_waddr     = sweep_r;
    mem_wdata     = 8'd0;
    unique case (state_r)
      rfor_pkg::S_INIT: begin
        mem_we = 1'b1;
        sweep_nxt = sweep_r + AW'(1);
        if (sweep_r == LAST_ADDR) begin
          state_nxt = rfor_pkg::S_IDLE;
        end
      end
      rfor_pkg::S_IDLE: begin
        if (in_acc) begin
          unique case (in_req.cmd)
            rfor_pkg::CMD_CLEAR: begin
              state_nxt = rfor_pkg::S_CLEAR;
              stop_nxt  = 1'b0;
              sweep_nxt = '0;
            end
            rfor_pkg::CMD_DRAW: begin
              if (stop_r) begin
                out_valid_nxt      = 1'b1;
                out_res_nxt.status = rfor_pkg::STAT_IGNORED;
              end else if (rect_bad) begin
                out_valid_nxt      = 1'b1;
                out_res_nxt.status = rfor_pkg::STAT_INVALID;
                stop_nxt           = 1'b1;
              end else begin
                state_nxt = rfor_pkg::S_DRAW;
                row_nxt   = '0;
                col_nxt   = '0;
              end
            end
            rfor_pkg::CMD_READ: begin
              if (read_out) begin
                out_valid_nxt      = 1'b1;
                out_res_nxt.status = rfor_pkg::STAT_OUTSIDE;
              end else begin
                state_nxt = rfor_pkg::S_READ;
              end
            end
            rfor_pkg::CMD_NOP: begin
              out_valid_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end
      rfor_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = bg_r;
        sweep_nxt = sweep_r + AW'(1);
        if (sweep_r == LAST_ADDR) begin
          state_nxt     = rfor_pkg::S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      rfor_pkg::S_DRAW: begin
        mem_waddr = AW'(AW'(row_r) * AW'(MAX_SIDE) + AW'(col_r));
        mem_wdata = fc_r;
        if (row_r == h_eff) begin
          state_nxt     = rfor_pkg::S_IDLE;
          out_valid_nxt = 1'b1;
        end else if (col_r == w_eff) begin
          col_nxt = '0;
          row_nxt = row_r + CNTW'(1);
        end else begin
          mem_we  = covered;
          col_nxt = col_r + CNTW'(1);
        end
      end
      rfor_pkg::S_READ: begin
        state_nxt              = rfor_pkg::S_IDLE;
        out_valid_nxt          = 1'b1;
        out_res_nxt.pixel_char = rd_data_r;
      end
      default: begin
        state_nxt = rfor_pkg::S_IDLE;
      end
    endcase
  end

  `RFOR_ASSERT_NEXT(a_acc_progress, in_acc, busy || out_valid, "request not taken up")
  `RFOR_ASSERT_NOW(a_out_idle, out_valid |-> !busy, "result shown while busy")
  `RFOR_ASSERT_NOW(a_we_state, mem_we |-> busy && (state_r != rfor_pkg::S_READ), "write off sweep")
  `RFOR_ASSERT_NOW(a_stop_src, $rose(stop_r) |-> $past(in_acc), "draw stop set without a request")

endmodule
